[rtl/mpjs_pkg.sv]
// ----------------------------------------------------------------------------
// mpjs_pkg
// Types and constants of the multi-policy job scheduler.
// ----------------------------------------------------------------------------
package mpjs_pkg;
    localparam int MaxJobs  = 16;
    localparam int SlotBits = 4;
    localparam int TimeBits = 32;
    localparam int SumBits  = 48;
    localparam int CntBits  = 16;
    localparam int NumBits  = 31;
    localparam int PriBits  = 16;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_EXPIRE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [2:0] POL_FCFS  = 3'd0;
    localparam logic [2:0] POL_PRI   = 3'd1;
    localparam logic [2:0] POL_PPRI  = 3'd2;
    localparam logic [2:0] POL_PSRTF = 3'd3;
    localparam logic [2:0] POL_RR    = 3'd4;
    localparam logic [2:0] POL_SJF   = 3'd5;

    typedef struct packed {
        logic [1:0]          operation;
        logic                running_valid;
        logic [SlotBits-1:0] slot;
        logic [NumBits-1:0]  job_tag;
        logic [TimeBits-1:0] now;
        logic [TimeBits-1:0] burst_len;
        logic [PriBits-1:0]  priority_req;
    } t_req;

    typedef struct packed {
        logic                dispatch_valid;
        logic [SlotBits-1:0] dispatch_slot;
        logic                insert_rejected;
        logic [SumBits-1:0]  waiting_sum;
        logic [SumBits-1:0]  turnaround_sum;
        logic [SumBits-1:0]  response_sum;
        logic [CntBits-1:0]  job_count;
    } t_rsp;

    typedef struct packed {
        logic [NumBits-1:0]  number;
        logic [TimeBits-1:0] arrival;
        logic [TimeBits-1:0] first_start;
        logic [TimeBits-1:0] burst_len;
        logic [TimeBits-1:0] aged_key;
        logic [PriBits-1:0]  base_priority;
        logic                started;
        logic [TimeBits-1:0] last_dispatch;
        logic [TimeBits-1:0] remaining;
    } t_entry;

    function automatic logic [TimeBits-1:0] key_of(logic [2:0] pol, t_entry e);
        case (pol)
            POL_PRI, POL_PPRI: key_of = {{(TimeBits-PriBits){1'b0}}, e.base_priority};
            POL_PSRTF:         key_of = e.remaining;
            POL_RR:            key_of = e.aged_key;
            POL_SJF:           key_of = e.burst_len;
            default:           key_of = e.arrival;
        endcase
    endfunction

    function automatic logic [TimeBits-1:0] sub_clamp(logic [TimeBits-1:0] a,
                                                      logic [TimeBits-1:0] b);
        sub_clamp = (a > b) ? a - b : '0;
    endfunction
endpackage

[rtl/mpjs_if.sv]
// ----------------------------------------------------------------------------
// mpjs_if
// Valid/ready channel carrying one request or one result.
// ----------------------------------------------------------------------------
interface mpjs_req_if;
    import mpjs_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mpjs_rsp_if;
    import mpjs_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/mpjs_table.sv]
// ----------------------------------------------------------------------------
// mpjs_table
// Job table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpjs_table (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [mpjs_pkg::SlotBits-1:0] i_waddr,
    input  mpjs_pkg::t_entry              i_wdata,
    input  logic [mpjs_pkg::SlotBits-1:0] i_raddr,
    output mpjs_pkg::t_entry              o_rdata
);
    import mpjs_pkg::*;
    t_entry r_mem [MaxJobs];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/multi_policy_job_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler_unit
// Job table scheduler with six ordering schemes and saturating statistics.
//
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   operation .. priority_req
//  o_rsp     out  valid/ready   dispatch flags, sums, job count
//  cfg       in   i_cfg_we      policy (3 bits)
//
// A request is read from the table (S_RD), executed (S_EXEC) and its result
// registered (S_DONE). A quantum expiry that has to pick from the queue adds a
// read-modify-write of the running slot, a scan of the 16 entries through the
// table's single read port (S_SCAN, S_CMP), then the write of the winner (S_WIN).
// Reset is synchronous and clears the queued bits, sums and count.
// The result waits in an output register; a new request is taken only in
// S_IDLE, once the previous result has gone.
// ----------------------------------------------------------------------------
module multi_policy_job_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    mpjs_req_if.sink    i_req,
    mpjs_rsp_if.source  o_rsp
);
    import mpjs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_WIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_policy;
    logic [MaxJobs-1:0]  r_queued, n_queued;
    t_req                r_req;
    logic [SumBits-1:0]  r_wsum, r_tsum, r_rsum, n_wsum, n_tsum, n_rsum;
    logic [CntBits-1:0]  r_count, n_count;
    logic [SlotBits:0]   r_idx, n_idx;
    logic [SlotBits-1:0] r_cur, n_cur, r_best, n_best;
    logic                r_have, n_have;
    logic [TimeBits-1:0] r_bkey, n_bkey, r_barr, n_barr;
    logic [NumBits-1:0]  r_bnum, n_bnum;
    logic                r_ovalid, n_ovalid;
    t_rsp                r_out, n_out;

    logic                we;
    logic [SlotBits-1:0] waddr, raddr;
    t_entry              wdata, rdata;

    mpjs_table u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    function automatic logic [SumBits-1:0] sat_add(logic [SumBits-1:0] a,
                                                    logic [TimeBits-1:0] b);
        logic [SumBits:0] s;
        s = {1'b0, a} + {{(SumBits+1-TimeBits){1'b0}}, b};
        sat_add = s[SumBits] ? '1 : s[SumBits-1:0];
    endfunction

    logic preempt;
    logic [TimeBits-1:0] turn, ckey;
    logic [TimeBits:0]   aged;
    logic better;

    assign preempt = (r_policy == POL_PPRI) || (r_policy == POL_PSRTF) ||
                     (r_policy == POL_RR);
    assign turn    = sub_clamp(r_req.now, rdata.arrival);
    assign aged    = {1'b0, rdata.aged_key} + {{(TimeBits+1-CntBits){1'b0}}, r_count};
    assign ckey    = key_of(r_policy, rdata);
    assign better  = !r_have || (ckey < r_bkey) ||
                     (ckey == r_bkey && rdata.arrival < r_barr) ||
                     (ckey == r_bkey && rdata.arrival == r_barr && rdata.number < r_bnum);

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_queued = r_queued;
        n_wsum   = r_wsum;
        n_tsum   = r_tsum;
        n_rsum   = r_rsum;
        n_count  = r_count;
        n_idx    = r_idx;
        n_cur    = r_cur;
        n_best   = r_best;
        n_have   = r_have;
        n_bkey   = r_bkey;
        n_barr   = r_barr;
        n_bnum   = r_bnum;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_out    = r_out;
        we       = 1'b0;
        waddr    = r_req.slot;
        wdata    = rdata;
        raddr    = r_req.slot;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_out.dispatch_valid  = 1'b0;
                n_out.dispatch_slot   = '0;
                n_out.insert_rejected = 1'b0;
                n_state = S_DONE;
                n_idx   = '0;
                n_have  = 1'b0;
                case (r_req.operation)
                    OP_NEW: begin
                        if (r_queued[r_req.slot]) begin
                            n_out.insert_rejected = 1'b1;
                        end else begin
                            we = 1'b1;
                            wdata.number        = r_req.job_tag;
                            wdata.arrival       = r_req.now;
                            wdata.burst_len     = r_req.burst_len;
                            wdata.remaining     = r_req.burst_len;
                            wdata.base_priority = r_req.priority_req;
                            wdata.aged_key      = {{(TimeBits-PriBits){1'b0}},
                                                   r_req.priority_req};
                            wdata.started       = 1'b0;
                            wdata.first_start   = '0;
                            wdata.last_dispatch = '0;
                            n_queued[r_req.slot] = 1'b1;
                            if (r_count != '1) n_count = r_count + 1'b1;
                        end
                    end
                    OP_EXPIRE: begin
                        n_state = S_SCAN;
                        if (r_req.running_valid) begin
                            we = 1'b1;
                            if (rdata.started) begin
                                wdata.remaining = sub_clamp(rdata.remaining,
                                    sub_clamp(r_req.now, rdata.last_dispatch));
                            end else begin
                                wdata.first_start = r_req.now;
                            end
                            wdata.started       = 1'b1;
                            wdata.last_dispatch = r_req.now;
                            if (!preempt) begin
                                n_state = S_DONE;
                                n_out.dispatch_valid = 1'b1;
                                n_out.dispatch_slot  = r_req.slot;
                            end else begin
                                wdata.aged_key = aged[TimeBits] ? '1 : aged[TimeBits-1:0];
                                n_queued[r_req.slot] = 1'b1;
                            end
                        end
                    end
                    OP_FINISH: begin
                        n_queued[r_req.slot] = 1'b0;
                        n_tsum = sat_add(r_tsum, turn);
                        n_wsum = sat_add(r_wsum, sub_clamp(turn, rdata.burst_len));
                        n_rsum = sat_add(r_rsum, rdata.started ?
                                 sub_clamp(rdata.first_start, rdata.arrival) : '0);
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                raddr = r_idx[SlotBits-1:0];
                n_cur = r_idx[SlotBits-1:0];
                n_idx = r_idx + 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_queued[r_cur] && better) begin
                    n_have = 1'b1;
                    n_best = r_cur;
                    n_bkey = ckey;
                    n_barr = rdata.arrival;
                    n_bnum = rdata.number;
                end
                raddr = r_idx[SlotBits-1:0];
                n_cur = r_idx[SlotBits-1:0];
                n_idx = r_idx + 1'b1;
                if (r_idx[SlotBits]) begin
                    raddr   = n_best;
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                n_state = S_DONE;
                if (r_have) begin
                    we    = 1'b1;
                    waddr = r_best;
                    if (!rdata.started) wdata.first_start = r_req.now;
                    wdata.started       = 1'b1;
                    wdata.last_dispatch = r_req.now;
                    n_queued[r_best]     = 1'b0;
                    n_out.dispatch_valid = 1'b1;
                    n_out.dispatch_slot  = r_best;
                end
            end
            S_DONE: begin
                n_out.waiting_sum    = r_wsum;
                n_out.turnaround_sum = r_tsum;
                n_out.response_sum   = r_rsum;
                n_out.job_count      = r_count;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= POL_FCFS;
            r_queued <= '0;
            r_wsum   <= '0;
            r_tsum   <= '0;
            r_rsum   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_policy <= i_cfg_wdata;
            r_queued <= n_queued;
            r_wsum   <= n_wsum;
            r_tsum   <= n_tsum;
            r_rsum   <= n_rsum;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_have   <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_req <= i_req.data;
        r_idx  <= n_idx;
        r_cur  <= n_cur;
        r_best <= n_best;
        r_bkey <= n_bkey;
        r_barr <= n_barr;
        r_bnum <= n_bnum;
        r_out  <= n_out;
    end
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Job scheduler check: a local scheduler model predicts every result while
// requests and result stalls arrive at random, across all ordering schemes.
// ----------------------------------------------------------------------------
module tb;
    import mpjs_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam logic [SumBits-1:0] SumMax = '1;
    localparam logic [1:0] OpSpare    = 2'd3;
    localparam logic [2:0] PolSpareLo = 3'd6;
    localparam logic [2:0] PolSpareHi = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_wdata;

    mpjs_req_if req_ch ();
    mpjs_rsp_if rsp_ch ();

    multi_policy_job_scheduler_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // scheduler model state
    logic [2:0]          mdl_policy;
    t_entry              mdl_tab [MaxJobs];
    logic                mdl_queued [MaxJobs];
    logic                mdl_written [MaxJobs];
    logic [SumBits-1:0]  mdl_wait, mdl_turn, mdl_resp;
    logic [CntBits-1:0]  mdl_count;
    logic [TimeBits-1:0] clock_now;

    t_rsp rsp_expected [$];
    int   n_errors, n_reqs, n_rsps, n_dispatches, idle_cycles;
    bit   rsp_stall;

    function automatic logic [SumBits-1:0] sum_add(logic [SumBits-1:0] a,
                                                   logic [TimeBits-1:0] b);
        logic [SumBits:0] s;
        s = {1'b0, a} + {{(SumBits+1-TimeBits){1'b0}}, b};
        sum_add = s[SumBits] ? SumMax : s[SumBits-1:0];
    endfunction

    function automatic logic [TimeBits-1:0] time_sub(logic [TimeBits-1:0] a,
                                                     logic [TimeBits-1:0] b);
        time_sub = (a > b) ? a - b : '0;
    endfunction

    function automatic logic [TimeBits-1:0] order_key(int i);
        case (mdl_policy)
            POL_PRI, POL_PPRI: order_key = {16'b0, mdl_tab[i].base_priority};
            POL_PSRTF:         order_key = mdl_tab[i].remaining;
            POL_RR:            order_key = mdl_tab[i].aged_key;
            POL_SJF:           order_key = mdl_tab[i].burst_len;
            default:           order_key = mdl_tab[i].arrival;
        endcase
    endfunction

    function automatic bit ranks_ahead(int i, int j);
        if (order_key(i) != order_key(j)) return order_key(i) < order_key(j);
        if (mdl_tab[i].arrival != mdl_tab[j].arrival)
            return mdl_tab[i].arrival < mdl_tab[j].arrival;
        return mdl_tab[i].number < mdl_tab[j].number;
    endfunction

    function automatic int dispatch_best(logic [TimeBits-1:0] now);
        int best;
        best = -1;
        for (int i = 0; i < MaxJobs; i++)
            if (mdl_queued[i] && (best < 0 || ranks_ahead(i, best))) best = i;
        if (best >= 0) begin
            mdl_queued[best] = 1'b0;
            if (!mdl_tab[best].started) mdl_tab[best].first_start = now;
            mdl_tab[best].started = 1'b1;
            mdl_tab[best].last_dispatch = now;
        end
        return best;
    endfunction

    function automatic t_rsp schedule_step(t_req r);
        t_rsp o;
        int pick, s;
        logic [TimeBits:0] ak;
        logic [TimeBits-1:0] turn;
        o = '0;
        s = r.slot;
        pick = -1;
        case (r.operation)
            OP_NEW: begin
                if (mdl_queued[s]) o.insert_rejected = 1'b1;
                else begin
                    mdl_queued[s] = 1'b1;
                    mdl_written[s] = 1'b1;
                    mdl_tab[s].number = r.job_tag;
                    mdl_tab[s].arrival = r.now;
                    mdl_tab[s].burst_len = r.burst_len;
                    mdl_tab[s].remaining = r.burst_len;
                    mdl_tab[s].base_priority = r.priority_req;
                    mdl_tab[s].aged_key = {16'b0, r.priority_req};
                    mdl_tab[s].started = 1'b0;
                    mdl_tab[s].first_start = '0;
                    mdl_tab[s].last_dispatch = '0;
                    if (mdl_count != '1) mdl_count++;
                end
            end
            OP_EXPIRE: begin
                if (r.running_valid) begin
                    if (mdl_tab[s].started)
                        mdl_tab[s].remaining = time_sub(mdl_tab[s].remaining,
                            time_sub(r.now, mdl_tab[s].last_dispatch));
                    else mdl_tab[s].first_start = r.now;
                    mdl_tab[s].started = 1'b1;
                    mdl_tab[s].last_dispatch = r.now;
                    if (!(mdl_policy inside {POL_PPRI, POL_PSRTF, POL_RR})) pick = s;
                    else begin
                        ak = {1'b0, mdl_tab[s].aged_key} +
                             {{(TimeBits+1-CntBits){1'b0}}, mdl_count};
                        mdl_tab[s].aged_key = ak[TimeBits] ? '1 : ak[TimeBits-1:0];
                        mdl_queued[s] = 1'b1;
                        pick = dispatch_best(r.now);
                    end
                end else pick = dispatch_best(r.now);
                if (pick >= 0) begin
                    o.dispatch_valid = 1'b1;
                    o.dispatch_slot = pick[SlotBits-1:0];
                end
            end
            OP_FINISH: begin
                turn = time_sub(r.now, mdl_tab[s].arrival);
                mdl_turn = sum_add(mdl_turn, turn);
                mdl_wait = sum_add(mdl_wait, time_sub(turn, mdl_tab[s].burst_len));
                if (mdl_tab[s].started)
                    mdl_resp = sum_add(mdl_resp,
                        time_sub(mdl_tab[s].first_start, mdl_tab[s].arrival));
                mdl_queued[s] = 1'b0;
            end
            default: ;
        endcase
        o.waiting_sum = mdl_wait;
        o.turnaround_sum = mdl_turn;
        o.response_sum = mdl_resp;
        o.job_count = mdl_count;
        return o;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
               ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        gap = short_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        rsp_expected.push_back(schedule_step(r));
        n_reqs++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (rsp_expected.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic set_policy(logic [2:0] p);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= p;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_policy = p;
    endtask

    function automatic t_req make_req(logic [1:0] op, int s, bit rv);
        t_req r;
        r.operation = op;
        r.running_valid = rv;
        r.slot = s[SlotBits-1:0];
        r.job_tag = NumBits'($urandom() >> 1);
        r.priority_req = PriBits'($urandom());
        if ($urandom_range(0, 3) == 0) r.burst_len = $urandom();
        else r.burst_len = $urandom_range(1, 200);
        if ($urandom_range(0, 30) == 0) r.now = $urandom();
        else begin
            clock_now = clock_now + $urandom_range(0, 50);
            r.now = clock_now;
        end
        return r;
    endfunction

    task automatic test_directed();
        t_req r;
        r = make_req(OP_EXPIRE, 0, 1'b0);
        send_request(r);
        r = make_req(OP_NEW, 0, 1'b0);
        r.job_tag = '1; r.burst_len = '1; r.priority_req = '1; r.now = '0;
        send_request(r);
        r.operation = OP_NEW;
        send_request(r);
        r = make_req(OP_NEW, 15, 1'b0);
        r.job_tag = '0; r.burst_len = '0; r.priority_req = '0; r.now = '1;
        send_request(r);
        r = make_req(OP_NEW, 5, 1'b0);
        r.priority_req = '0; r.now = '0; r.job_tag = 3;
        send_request(r);
        send_request(make_req(OP_EXPIRE, 0, 1'b0));
        send_request(make_req(OP_EXPIRE, 0, 1'b1));
        r = make_req(OP_FINISH, 15, 1'b0);
        r.now = '0;
        send_request(r);
        r = make_req(OP_FINISH, 0, 1'b0);
        r.now = '1;
        send_request(r);
        r = make_req(OpSpare, 4, 1'b1);
        send_request(r);
        send_request(make_req(OP_EXPIRE, 5, 1'b1));
        send_request(make_req(OP_FINISH, 5, 1'b0));
    endtask

    // mostly sane job lifecycles, with some broken ones mixed in
    task automatic test_random_jobs(int n, logic [2:0] pol);
        int run_slot, s;
        t_req r;
        set_policy(pol);
        run_slot = -1;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r = make_req(OP_NEW, $urandom_range(0, 15), 1'b0);
                4, 5, 6: r = make_req(OP_EXPIRE, run_slot < 0 ? 0 : run_slot, run_slot >= 0);
                7, 8: begin
                    s = run_slot < 0 ? $urandom_range(0, 15) : run_slot;
                    if (!mdl_written[s]) s = run_slot < 0 ? 0 : run_slot;
                    r = make_req(OP_FINISH, s, 1'b0);
                    if (!mdl_written[s]) r.operation = OP_NEW;
                end
                default: begin
                    r = make_req(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                                 1'($urandom_range(0, 1)));
                    if (r.operation inside {OP_EXPIRE, OP_FINISH} &&
                        !mdl_written[r.slot]) r.running_valid = 1'b0;
                    if (r.operation == OP_FINISH && !mdl_written[r.slot])
                        r.operation = OP_NEW;
                end
            endcase
            if (r.operation == OP_FINISH && r.slot == run_slot) run_slot = -1;
            send_request(r);
            if (r.operation == OP_EXPIRE && rsp_expected[$].dispatch_valid)
                run_slot = rsp_expected[$].dispatch_slot;
            else if (r.operation == OP_EXPIRE) run_slot = -1;
            if (r.operation == OP_FINISH && rsp_expected.size() > 0 &&
                r.slot == run_slot) run_slot = -1;
        end
    endtask

    task automatic test_policy_sweep();
        test_random_jobs(240, POL_FCFS);
        test_random_jobs(240, POL_PRI);
        test_random_jobs(240, POL_PPRI);
        test_random_jobs(240, POL_PSRTF);
        test_random_jobs(240, POL_RR);
        test_random_jobs(240, POL_SJF);
        test_random_jobs(60, PolSpareHi);
        test_random_jobs(60, PolSpareLo);
    endtask

    // result checker, stalls the result side at random
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            idle_cycles = 0;
            n_rsps++;
            if (rsp_expected.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", rsp_ch.data);
            end else begin
                if (rsp_ch.data !== rsp_expected[0]) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %p actual %p",
                                 rsp_expected[0], rsp_ch.data);
                end
                if (rsp_expected[0].dispatch_valid) n_dispatches++;
                void'(rsp_expected.pop_front());
            end
        end else if (i_rst_n && !(req_ch.valid && req_ch.ready)) begin
            idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("watchdog: no progress, %0d results pending",
                         rsp_expected.size());
                $display("tb: done, errors");
                $finish;
            end
        end else idle_cycles = 0;
    end

    always @(negedge i_clk) begin
        if (rsp_stall) rsp_stall = $urandom_range(0, 5) != 0;
        else rsp_stall = $urandom_range(0, 7) == 0;
        rsp_ch.ready <= (n_reqs > 400 && n_reqs < 600) ? 1'b1 : !rsp_stall;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        rsp_stall = 1'b0;
        n_errors = 0; n_reqs = 0; n_rsps = 0; n_dispatches = 0; idle_cycles = 0;
        mdl_policy = POL_FCFS;
        mdl_wait = '0; mdl_turn = '0; mdl_resp = '0; mdl_count = '0;
        clock_now = '0;
        for (int i = 0; i < MaxJobs; i++) begin
            mdl_tab[i] = '0; mdl_queued[i] = 1'b0; mdl_written[i] = 1'b0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_policy_sweep();
        wait_drained();
        $display("covered %0d requests, %0d results, %0d dispatches over 8 schemes",
                 n_reqs, n_rsps, n_dispatches);
        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/mpjs_pkg.sv
rtl/mpjs_if.sv
rtl/mpjs_table.sv
rtl/multi_policy_job_scheduler_unit.sv
tb/sv/tb.sv
